### sv/ccmt_pkg.sv
// Shared types and constants for the color match centroid tracker.
`default_nettype none

package ccmt_pkg;

  localparam int PIX_W      = 8;
  localparam int FW_W       = 13;
  localparam int CENTER_W   = 12;
  localparam int SUM_W      = 36;
  localparam int COUNT_W    = 25;
  localparam int PEND_W     = CENTER_W + 1;
  localparam int QUOT_W     = CENTER_W + 1;
  localparam int SQ_W       = 2 * PIX_W;
  localparam int DIST_W     = SQ_W + 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = FW_W;
  localparam int QUEUE_DEPTH = 2;

  localparam int MAX_WIDTH_DEF  = 4096;
  localparam int MAX_HEIGHT_DEF = 4096;

  localparam logic [FW_W-1:0] FRAME_WIDTH_RST = FW_W'(640);

  typedef struct packed {
    logic [PIX_W-1:0] pixel_red;
    logic [PIX_W-1:0] pixel_green;
    logic [PIX_W-1:0] pixel_blue;
    logic             frame_last;
  } in_item_t;

  typedef struct packed {
    logic [PIX_W-1:0]    out_red;
    logic [PIX_W-1:0]    out_green;
    logic [PIX_W-1:0]    out_blue;
    logic                matched;
    logic [CENTER_W-1:0] center_x;
    logic [CENTER_W-1:0] center_y;
    logic                center_updated;
  } out_item_t;

  typedef struct packed {
    logic [PIX_W-1:0] target_red;
    logic [PIX_W-1:0] target_green;
    logic [PIX_W-1:0] target_blue;
    logic [PIX_W-1:0] match_threshold;
    logic [FW_W-1:0]  frame_width;
  } cfg_t;

  // classified pixel moving from front to back
  typedef struct packed {
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
    logic             last;
    logic             hit;
  } cls_item_t;

  typedef struct packed {
    logic               start;
    logic [SUM_W-1:0]   sum_x;
    logic [SUM_W-1:0]   sum_y;
    logic [COUNT_W-1:0] count;
  } div_req_t;

  typedef struct packed {
    logic                busy;
    logic                done;
    logic [CENTER_W-1:0] quot_x;
    logic [CENTER_W-1:0] quot_y;
  } div_rsp_t;

endpackage

`default_nettype wire

### sv/color_match_centroid_tracker_unit.sv
// Top level of the color match centroid tracker.
//
//   port group | dir | handshake           | payload
//   in_        | in  | in_valid/in_ready   | in_data (in_item_t)
//   out_       | out | out_valid/out_ready | out_data (out_item_t)
//   cfg_       | in  | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// One pixel per clock unless out_ready or the divider stalls it; the output is registered.
// A frame end with matches in phase 0 or 1 starts a 13-step centroid divide (pending is
// updated when the divider raises done); the next frame's last pixel waits at the queue
// head until then.
// Reset is synchronous, active low; no clearing pass is needed.
// Front and back stall independently around a 2-entry queue; out_ready low holds the output.
`default_nettype none

module color_match_centroid_tracker_unit import ccmt_pkg::*; #(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam logic [CFG_IDX_W-1:0] REG_TARGET_RED   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_GREEN = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_BLUE  = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD    = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = CFG_IDX_W'(4);

  cfg_t      cfg_r, cfg_nxt;
  logic      push, queue_full, pop, head_valid;
  cls_item_t push_item, head;
  div_req_t  div_req;
  div_rsp_t  div_rsp;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_TARGET_RED:   cfg_nxt.target_red      = cfg_data[PIX_W-1:0];
        REG_TARGET_GREEN: cfg_nxt.target_green    = cfg_data[PIX_W-1:0];
        REG_TARGET_BLUE:  cfg_nxt.target_blue     = cfg_data[PIX_W-1:0];
        REG_THRESHOLD:    cfg_nxt.match_threshold = cfg_data[PIX_W-1:0];
        REG_FRAME_WIDTH:  cfg_nxt.frame_width     = cfg_data[FW_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.target_red      <= '0;
      cfg_r.target_green    <= '0;
      cfg_r.target_blue     <= '0;
      cfg_r.match_threshold <= '0;
      cfg_r.frame_width     <= FRAME_WIDTH_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  ccmt_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .cfg        (cfg_r),
    .push       (push),
    .push_item  (push_item),
    .queue_full (queue_full)
  );

  ccmt_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_item  (push_item),
    .full       (queue_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  ccmt_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  ccmt_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .head_valid  (head_valid),
    .head        (head),
    .pop         (pop),
    .frame_width (cfg_r.frame_width),
    .div_req     (div_req),
    .div_rsp     (div_rsp),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data)
  );

endmodule

`default_nettype wire

### sv/ccmt_front.sv
// Front end: takes pixels and classifies them against the target color.
`default_nettype none

module ccmt_front import ccmt_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  input  cfg_t      cfg,
  output logic      push,
  output cls_item_t push_item,
  input  logic      queue_full
);

  logic            s1_valid_r, s1_valid_nxt;
  in_item_t        s1_pix_r;
  logic [SQ_W-1:0] sq_red_r, sq_green_r, sq_blue_r;
  logic [DIST_W-1:0] dist_sum;
  logic [SQ_W-1:0]   thr_sq;
  logic              take;

  function automatic logic [SQ_W-1:0] sq_diff(input logic [PIX_W-1:0] a,
                                               input logic [PIX_W-1:0] b);
    logic [PIX_W-1:0] d;
    d = (a > b) ? (a - b) : (b - a);
    return SQ_W'(d) * SQ_W'(d);
  endfunction

  assign take     = in_valid && in_ready;
  assign push     = s1_valid_r && !queue_full;
  assign in_ready = !s1_valid_r || !queue_full;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (take) begin
      s1_valid_nxt = 1'b1;
    end else if (push) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_pix_r   <= in_data;
      sq_red_r   <= sq_diff(in_data.pixel_red,   cfg.target_red);
      sq_green_r <= sq_diff(in_data.pixel_green, cfg.target_green);
      sq_blue_r  <= sq_diff(in_data.pixel_blue,  cfg.target_blue);
    end
  end

  // exact integer test: dist^2 < thr^2
  assign dist_sum = DIST_W'(sq_red_r) + DIST_W'(sq_green_r) + DIST_W'(sq_blue_r);
  assign thr_sq   = SQ_W'(cfg.match_threshold) * SQ_W'(cfg.match_threshold);

  always_comb begin
    push_item.red   = s1_pix_r.pixel_red;
    push_item.green = s1_pix_r.pixel_green;
    push_item.blue  = s1_pix_r.pixel_blue;
    push_item.last  = s1_pix_r.frame_last;
    push_item.hit   = dist_sum < DIST_W'(thr_sq);
  end

endmodule

`default_nettype wire

### sv/ccmt_queue.sv
// Short queue of classified pixels between front and back.
`default_nettype none

module ccmt_queue import ccmt_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  cls_item_t push_item,
  output logic      full,
  input  logic      pop,
  output logic      head_valid,
  output cls_item_t head
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

  cls_item_t        slot_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full       = (count_r == CNT_FULL);
  assign head_valid = (count_r != '0);
  assign head       = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

`default_nettype wire

### sv/ccmt_div.sv
// Restoring divider for the frame centroid, x and y share one divisor.
`default_nettype none

module ccmt_div import ccmt_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam int REM_W  = SUM_W + 1;
  localparam int STEP_W = $clog2(QUOT_W);
  localparam logic [STEP_W-1:0] STEP_FIRST = STEP_W'(QUOT_W - 1);

  logic [REM_W-1:0]  rem_x_r, rem_x_nxt, rem_y_r, rem_y_nxt;
  logic [REM_W-1:0]  dvs_r, dvs_nxt;
  logic [QUOT_W-1:0] quo_x_r, quo_x_nxt, quo_y_r, quo_y_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic              ge_x, ge_y;

  assign ge_x = (rem_x_r >= dvs_r);
  assign ge_y = (rem_y_r >= dvs_r);

  // quotient bit 12 set means the centroid is past 4095 and clamps
  always_comb begin
    rem_x_nxt = rem_x_r;
    rem_y_nxt = rem_y_r;
    dvs_nxt   = dvs_r;
    quo_x_nxt = quo_x_r;
    quo_y_nxt = quo_y_r;
    step_nxt  = step_r;
    busy_nxt  = busy_r;
    done_nxt  = 1'b0;
    if (req.start) begin
      rem_x_nxt = REM_W'(req.sum_x);
      rem_y_nxt = REM_W'(req.sum_y);
      dvs_nxt   = REM_W'(req.count) << CENTER_W;
      quo_x_nxt = '0;
      quo_y_nxt = '0;
      step_nxt  = STEP_FIRST;
      busy_nxt  = 1'b1;
    end else if (busy_r) begin
      if (ge_x) begin
        rem_x_nxt = rem_x_r - dvs_r;
      end
      if (ge_y) begin
        rem_y_nxt = rem_y_r - dvs_r;
      end
      quo_x_nxt = {quo_x_r[QUOT_W-2:0], ge_x};
      quo_y_nxt = {quo_y_r[QUOT_W-2:0], ge_y};
      dvs_nxt   = dvs_r >> 1;
      if (step_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        step_nxt = step_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_x_r <= rem_x_nxt;
    rem_y_r <= rem_y_nxt;
    dvs_r   <= dvs_nxt;
    quo_x_r <= quo_x_nxt;
    quo_y_r <= quo_y_nxt;
  end

  always_comb begin
    rsp.busy   = busy_r || done_r;
    rsp.done   = done_r;
    rsp.quot_x = quo_x_r[QUOT_W-1] ? '1 : quo_x_r[CENTER_W-1:0];
    rsp.quot_y = quo_y_r[QUOT_W-1] ? '1 : quo_y_r[CENTER_W-1:0];
  end

endmodule

`default_nettype wire

### sv/ccmt_back.sv
// Back end: position tracking, match sums, frame phase and the result register.
`default_nettype none

module ccmt_back import ccmt_pkg::*; #(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            head_valid,
  input  cls_item_t       head,
  output logic            pop,
  input  logic [FW_W-1:0] frame_width,
  output div_req_t        div_req,
  input  div_rsp_t        div_rsp,
  output logic            out_valid,
  input  logic            out_ready,
  output out_item_t       out_data
);

  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ROW_W  = $clog2(MAX_HEIGHT);
  localparam int WCMP_W = (((COL_W + 1) > FW_W) ? (COL_W + 1) : FW_W) + 1;
  localparam logic [WCMP_W-1:0] WIDTH_LIM = WCMP_W'(MAX_WIDTH);
  localparam logic [ROW_W-1:0]  ROW_LAST  = ROW_W'(MAX_HEIGHT - 1);

  localparam logic [1:0] PHASE_FIRST  = 2'd0;
  localparam logic [1:0] PHASE_SECOND = 2'd1;

  logic [COL_W-1:0]    col_r, col_nxt;
  logic [ROW_W-1:0]    row_r, row_nxt;
  logic [SUM_W-1:0]    csum_r, csum_nxt, rsum_r, rsum_nxt;
  logic [COUNT_W-1:0]  cnt_r, cnt_nxt;
  logic [1:0]          phase_r, phase_nxt;
  logic [PEND_W-1:0]   pend_x_r, pend_x_nxt, pend_y_r, pend_y_nxt;
  logic [CENTER_W-1:0] held_x_r, held_x_nxt, held_y_r, held_y_nxt;
  logic                out_valid_r, out_valid_nxt;
  out_item_t           out_data_r, out_data_nxt;

  logic [WCMP_W-1:0]   weff;
  logic [WCMP_W-1:0]   col_inc;
  logic [SUM_W-1:0]    csum_upd, rsum_upd;
  logic [COUNT_W-1:0]  cnt_upd;
  logic                updated;

  function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
                                               input logic [SUM_W-1:0] b);
    logic [SUM_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[SUM_W] ? '1 : s[SUM_W-1:0];
  endfunction

  // a frame end may not overtake a centroid still being divided
  assign pop = head_valid && (!out_valid_r || out_ready) && !(head.last && div_rsp.busy);

  always_comb begin
    weff = WCMP_W'(frame_width);
    if (frame_width == '0) begin
      weff = WCMP_W'(1);
    end else if (weff > WIDTH_LIM) begin
      weff = WIDTH_LIM;
    end
  end

  assign col_inc = WCMP_W'(col_r) + WCMP_W'(1);

  always_comb begin
    col_nxt       = col_r;
    row_nxt       = row_r;
    csum_nxt      = csum_r;
    rsum_nxt      = rsum_r;
    cnt_nxt       = cnt_r;
    phase_nxt     = phase_r;
    pend_x_nxt    = pend_x_r;
    pend_y_nxt    = pend_y_r;
    held_x_nxt    = held_x_r;
    held_y_nxt    = held_y_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    updated       = 1'b0;
    div_req       = '0;

    csum_upd = csum_r;
    rsum_upd = rsum_r;
    cnt_upd  = cnt_r;
    if (head.hit) begin
      csum_upd = sat_add(csum_r, SUM_W'(col_r));
      rsum_upd = sat_add(rsum_r, SUM_W'(row_r));
      cnt_upd  = (cnt_r == '1) ? cnt_r : cnt_r + 1'b1;
    end

    if (div_rsp.done) begin
      pend_x_nxt = pend_x_r + PEND_W'(div_rsp.quot_x);
      pend_y_nxt = pend_y_r + PEND_W'(div_rsp.quot_y);
    end

    if (pop) begin
      csum_nxt = csum_upd;
      rsum_nxt = rsum_upd;
      cnt_nxt  = cnt_upd;
      if (col_inc >= weff) begin
        col_nxt = '0;
        if (row_r != ROW_LAST) begin
          row_nxt = row_r + 1'b1;
        end
      end else begin
        col_nxt = col_inc[COL_W-1:0];
      end

      if (head.last) begin
        if (cnt_upd != '0) begin
          if (phase_r == PHASE_FIRST || phase_r == PHASE_SECOND) begin
            div_req.start = 1'b1;
            div_req.sum_x = csum_upd;
            div_req.sum_y = rsum_upd;
            div_req.count = cnt_upd;
            phase_nxt     = phase_r + 2'd1;
          end else begin
            held_x_nxt = pend_x_r[PEND_W-1:1];
            held_y_nxt = pend_y_r[PEND_W-1:1];
            pend_x_nxt = '0;
            pend_y_nxt = '0;
            phase_nxt  = PHASE_FIRST;
            updated    = 1'b1;
          end
        end
        col_nxt  = '0;
        row_nxt  = '0;
        csum_nxt = '0;
        rsum_nxt = '0;
        cnt_nxt  = '0;
      end

      out_valid_nxt               = 1'b1;
      out_data_nxt.out_red        = head.hit ? '1 : head.red;
      out_data_nxt.out_green      = head.hit ? '0 : head.green;
      out_data_nxt.out_blue       = head.hit ? '0 : head.blue;
      out_data_nxt.matched        = head.hit;
      out_data_nxt.center_x       = held_x_nxt;
      out_data_nxt.center_y       = held_y_nxt;
      out_data_nxt.center_updated = updated;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r       <= '0;
      row_r       <= '0;
      csum_r      <= '0;
      rsum_r      <= '0;
      cnt_r       <= '0;
      phase_r     <= PHASE_FIRST;
      pend_x_r    <= '0;
      pend_y_r    <= '0;
      held_x_r    <= '0;
      held_y_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      csum_r      <= csum_nxt;
      rsum_r      <= rsum_nxt;
      cnt_r       <= cnt_nxt;
      phase_r     <= phase_nxt;
      pend_x_r    <= pend_x_nxt;
      pend_y_r    <= pend_y_nxt;
      held_x_r    <= held_x_nxt;
      held_y_r    <= held_y_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

### tb/sv/ccmt_tb_pkg.sv
// Register index codes shared by the tracker testbench and its checker.
`timescale 1ns / 100ps

package ccmt_tb_pkg;

  import ccmt_pkg::CFG_IDX_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TARGET_RED      = 3'd0,
    REG_TARGET_GREEN    = 3'd1,
    REG_TARGET_BLUE     = 3'd2,
    REG_MATCH_THRESHOLD = 3'd3,
    REG_FRAME_WIDTH     = 3'd4,
    REG_SPARE           = 3'd5
  } ccmt_reg_e;

endpackage

### tb/sv/ccmt_checker.sv
// Checker for the tracker: tracks config, predicts each output pixel, compares in order.
`timescale 1ns / 100ps

module ccmt_checker
  import ccmt_pkg::*;
  import ccmt_tb_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  in_item_t              in_data,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  out_item_t             out_data,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    fail_count,
  output int                    results_due
);

  localparam logic [SUM_W-1:0]   SUM_MAX    = '1;
  localparam logic [COUNT_W-1:0] COUNT_MAX  = '1;
  localparam int                 CENTER_MAX = 4095;

  cfg_t                cfg_now;
  logic [CENTER_W-1:0] col_pos, row_pos;
  logic [SUM_W-1:0]    col_sum, row_sum;
  logic [COUNT_W-1:0]  match_n;
  logic [1:0]          frame_phase;
  logic [PEND_W-1:0]   pend_x, pend_y;
  logic [CENTER_W-1:0] pub_x, pub_y;
  out_item_t           expected_pixels[$];

  function automatic int unsigned abs_diff(logic [PIX_W-1:0] a, logic [PIX_W-1:0] b);
    return (a > b) ? a - b : b - a;
  endfunction

  // advances the tracker state by one pixel and returns the pixel it should emit
  function automatic out_item_t next_pixel_result(in_item_t px);
    int unsigned      dr, dg, db, dist2, thr, width;
    logic             hit, published;
    logic [SUM_W:0]   acc_x, acc_y;
    logic [COUNT_W:0] acc_n;
    logic [SUM_W-1:0] q_x, q_y;
    out_item_t        res;
    dr = abs_diff(px.pixel_red, cfg_now.target_red);
    dg = abs_diff(px.pixel_green, cfg_now.target_green);
    db = abs_diff(px.pixel_blue, cfg_now.target_blue);
    dist2 = dr * dr + dg * dg + db * db;
    thr = cfg_now.match_threshold;
    hit = dist2 < thr * thr;
    published = 1'b0;
    width = cfg_now.frame_width;
    if (width == 0) width = 1;
    if (width > MAX_WIDTH_DEF) width = MAX_WIDTH_DEF;

    if (hit) begin
      acc_x = col_sum + col_pos;
      acc_y = row_sum + row_pos;
      acc_n = match_n + 1'b1;
      col_sum = (acc_x > SUM_MAX) ? SUM_MAX : acc_x[SUM_W-1:0];
      row_sum = (acc_y > SUM_MAX) ? SUM_MAX : acc_y[SUM_W-1:0];
      match_n = (acc_n > COUNT_MAX) ? COUNT_MAX : acc_n[COUNT_W-1:0];
    end

    if (32'(col_pos) + 1 >= width) begin
      col_pos = '0;
      if (32'(row_pos) + 1 < MAX_HEIGHT_DEF) row_pos = row_pos + 1'b1;
    end else begin
      col_pos = col_pos + 1'b1;
    end

    if (px.frame_last) begin
      if (match_n != 0) begin
        q_x = col_sum / match_n;
        q_y = row_sum / match_n;
        if (q_x > CENTER_MAX) q_x = CENTER_MAX;
        if (q_y > CENTER_MAX) q_y = CENTER_MAX;
        if (frame_phase < 2) begin
          pend_x = pend_x + q_x[CENTER_W-1:0];
          pend_y = pend_y + q_y[CENTER_W-1:0];
          frame_phase = frame_phase + 1'b1;
        end else begin
          // third frame publishes the average of the two pending ones
          pub_x = pend_x[PEND_W-1:1];
          pub_y = pend_y[PEND_W-1:1];
          pend_x = '0;
          pend_y = '0;
          frame_phase = '0;
          published = 1'b1;
        end
      end
      col_pos = '0;
      row_pos = '0;
      col_sum = '0;
      row_sum = '0;
      match_n = '0;
    end

    res.out_red = hit ? 8'hFF : px.pixel_red;
    res.out_green = hit ? 8'h00 : px.pixel_green;
    res.out_blue = hit ? 8'h00 : px.pixel_blue;
    res.matched = hit;
    res.center_x = pub_x;
    res.center_y = pub_y;
    res.center_updated = published;
    return res;
  endfunction

  task automatic check_field(string name, logic [CENTER_W-1:0] want, logic [CENTER_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      cfg_now.target_red = '0;
      cfg_now.target_green = '0;
      cfg_now.target_blue = '0;
      cfg_now.match_threshold = '0;
      cfg_now.frame_width = FRAME_WIDTH_RST;
      col_pos = '0;
      row_pos = '0;
      col_sum = '0;
      row_sum = '0;
      match_n = '0;
      frame_phase = '0;
      pend_x = '0;
      pend_y = '0;
      pub_x = '0;
      pub_y = '0;
      expected_pixels.delete();
      fail_count = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (ccmt_reg_e'(cfg_index))
          REG_TARGET_RED:      cfg_now.target_red = cfg_data[PIX_W-1:0];
          REG_TARGET_GREEN:    cfg_now.target_green = cfg_data[PIX_W-1:0];
          REG_TARGET_BLUE:     cfg_now.target_blue = cfg_data[PIX_W-1:0];
          REG_MATCH_THRESHOLD: cfg_now.match_threshold = cfg_data[PIX_W-1:0];
          REG_FRAME_WIDTH:     cfg_now.frame_width = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) expected_pixels.push_back(next_pixel_result(in_data));
      if (out_valid && out_ready) begin
        if (expected_pixels.size() == 0) begin
          $error("output transfer with no pixel outstanding");
          fail_count++;
        end else begin
          want = expected_pixels.pop_front();
          check_field("out_red", want.out_red, out_data.out_red);
          check_field("out_green", want.out_green, out_data.out_green);
          check_field("out_blue", want.out_blue, out_data.out_blue);
          check_field("matched", want.matched, out_data.matched);
          check_field("center_x", want.center_x, out_data.center_x);
          check_field("center_y", want.center_y, out_data.center_y);
          check_field("center_updated", want.center_updated, out_data.center_updated);
        end
      end
    end
    results_due = expected_pixels.size();
  end

endmodule

### tb/sv/tb_color_match_centroid_tracker_unit.sv
// Testbench top for the color match centroid tracker: stimulus, flow control and verdict.
`timescale 1ns / 100ps

module tb_color_match_centroid_tracker_unit;

  import ccmt_pkg::*;
  import ccmt_tb_pkg::*;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid, in_ready;
  in_item_t              in_data;
  logic                  out_valid, out_ready;
  out_item_t             out_data;
  logic                  cfg_valid, cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    fail_count, results_due;

  logic                  calm;
  logic [PIX_W-1:0]      tgt_r, tgt_g, tgt_b, thr_now;
  int                    frame_left, hit_pct;

  color_match_centroid_tracker_unit uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  ccmt_checker chk (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .results_due(results_due)
  );

  always #5 clk = ~clk;

  function automatic int gap_len();
    if ($urandom_range(0, 19) == 0) return $urandom_range(20, 40);
    return $urandom_range(1, 3);
  endfunction

  function automatic logic [PIX_W-1:0] near_byte(logic [PIX_W-1:0] c, int span);
    int v;
    v = int'(c) - span + int'($urandom_range(0, 2 * span));
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return 8'(v);
  endfunction

  // toggles between stretches with and without idle cycles
  initial begin
    calm = 1'b0;
    forever begin
      repeat ($urandom_range(50, 300)) @(posedge clk);
      calm = ~calm;
    end
  end

  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ready = 1'b1;
      if (!calm) begin
        repeat ($urandom_range(1, 8)) @(negedge clk);
        out_ready = 1'b0;
        repeat (gap_len()) @(negedge clk);
      end
    end
  end

  initial begin
    #50ms;
    $display("tb_color_match_centroid_tracker_unit: FAIL");
    $finish;
  end

  task automatic send_pixel(logic [PIX_W-1:0] r, logic [PIX_W-1:0] g, logic [PIX_W-1:0] b,
                            logic last);
    int idle_n;
    @(negedge clk);
    idle_n = (!calm && $urandom_range(0, 3) == 0) ? gap_len() : 0;
    if (idle_n > 0) begin
      in_valid = 1'b0;
      repeat (idle_n) @(negedge clk);
    end
    in_data = '{pixel_red: r, pixel_green: g, pixel_blue: b, frame_last: last};
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
  endtask

  // waits until every pixel has come back, plus headroom for the centroid divide
  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (results_due != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_reg(ccmt_reg_e idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_index = idx;
    cfg_data = val;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
    case (idx)
      REG_TARGET_RED:      tgt_r = val[PIX_W-1:0];
      REG_TARGET_GREEN:    tgt_g = val[PIX_W-1:0];
      REG_TARGET_BLUE:     tgt_b = val[PIX_W-1:0];
      REG_MATCH_THRESHOLD: thr_now = val[PIX_W-1:0];
      default: ;
    endcase
  endtask

  // unused upper data bits on the byte registers carry junk
  task automatic set_all(logic [PIX_W-1:0] r, logic [PIX_W-1:0] g, logic [PIX_W-1:0] b,
                         logic [PIX_W-1:0] thr, logic [CFG_DATA_W-1:0] fw);
    drain();
    write_reg(REG_TARGET_RED, {5'($urandom), r});
    write_reg(REG_TARGET_GREEN, {5'($urandom), g});
    write_reg(REG_TARGET_BLUE, {5'($urandom), b});
    write_reg(REG_MATCH_THRESHOLD, {5'($urandom), thr});
    write_reg(REG_FRAME_WIDTH, fw);
  endtask

  task automatic pick_pixel(int pct, output logic [PIX_W-1:0] r, output logic [PIX_W-1:0] g,
                            output logic [PIX_W-1:0] b);
    int span;
    if ($urandom_range(1, 100) <= pct) begin
      // half a nonzero threshold per channel always lands inside; full threshold straddles the edge
      span = $urandom_range(0, 1) ? thr_now / 2 : thr_now;
      r = near_byte(tgt_r, span);
      g = near_byte(tgt_g, span);
      b = near_byte(tgt_b, span);
    end else begin
      r = 8'($urandom);
      g = 8'($urandom);
      b = 8'($urandom);
    end
  endtask

  // only the tail of the frame matches, so the centroid sits at the far edge
  task automatic long_frame(logic [CFG_DATA_W-1:0] fw, int n_pix, int hit_from);
    logic [PIX_W-1:0] r, g, b;
    set_all(8'd0, 8'd0, 8'd0, 8'hFF, fw);
    for (int i = 0; i < n_pix; i++) begin
      if (i >= hit_from) begin
        pick_pixel(100, r, g, b);
      end else begin
        r = 8'hFF;
        g = 8'($urandom);
        b = 8'($urandom);
      end
      send_pixel(r, g, b, i == n_pix - 1);
    end
  endtask

  // frames may straddle a config change, which leaves a row half done
  task automatic run_stream(int n_items);
    logic [PIX_W-1:0] r, g, b;
    for (int i = 0; i < n_items; i++) begin
      if (frame_left == 0) begin
        frame_left = ($urandom_range(0, 9) == 0) ? $urandom_range(49, 120) : $urandom_range(1, 48);
        case ($urandom_range(0, 9))
          0:       hit_pct = 0;
          1:       hit_pct = 100;
          2, 3:    hit_pct = 20;
          default: hit_pct = 60;
        endcase
      end
      pick_pixel(hit_pct, r, g, b);
      send_pixel(r, g, b, frame_left == 1);
      frame_left--;
    end
  endtask

  initial begin
    logic [PIX_W-1:0]      pick_thr;
    logic [CFG_DATA_W-1:0] pick_fw;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    tgt_r = '0;
    tgt_g = '0;
    tgt_b = '0;
    thr_now = '0;
    frame_left = 0;
    hit_pct = 60;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    // reset settings: zero threshold, nothing matches even the exact target
    send_pixel(8'd0, 8'd0, 8'd0, 1'b0);
    send_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0);
    send_pixel(8'd0, 8'd0, 8'd0, 1'b1);

    // zero width behaves as one pixel per row; distance exactly at threshold misses
    set_all(8'd200, 8'd100, 8'd50, 8'd10, 13'd0);
    send_pixel(8'd200, 8'd100, 8'd50, 1'b0);
    send_pixel(8'd210, 8'd100, 8'd50, 1'b0);
    send_pixel(8'd200, 8'd91, 8'd50, 1'b0);
    send_pixel(8'd0, 8'd0, 8'd0, 1'b0);
    send_pixel(8'hFF, 8'hFF, 8'hFF, 1'b1);
    // frame without matches keeps the phase
    send_pixel(8'd0, 8'd0, 8'd0, 1'b0);
    send_pixel(8'hFF, 8'hFF, 8'hFF, 1'b1);
    send_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0);
    send_pixel(8'd203, 8'd104, 8'd50, 1'b1);
    // single-pixel frame, third with matches: publishes
    send_pixel(8'd200, 8'd100, 8'd50, 1'b1);

    // oversized width clamps; largest threshold with its boundary
    set_all(8'd0, 8'd0, 8'd0, 8'hFF, 13'h1FFF);
    send_pixel(8'd0, 8'd0, 8'd0, 1'b0);
    send_pixel(8'hFF, 8'd0, 8'd0, 1'b0);
    send_pixel(8'd254, 8'd0, 8'd0, 1'b0);
    send_pixel(8'd0, 8'hFF, 8'd0, 1'b0);
    send_pixel(8'd0, 8'd0, 8'hFF, 1'b1);
    drain();
    write_reg(REG_SPARE, 13'($urandom));

    // tall one-pixel-wide frame, then one long row at the clamped width
    long_frame(13'd1, 150, 140);
    long_frame(13'h1FFF, 150, 140);

    set_all(8'hFF, 8'hFF, 8'hFF, 8'hFF, 13'd4096);
    run_stream(100);
    repeat (7) begin
      case ($urandom_range(0, 9))
        0:       pick_thr = 8'd0;
        1:       pick_thr = 8'hFF;
        default: pick_thr = 8'($urandom_range(8, 90));
      endcase
      case ($urandom_range(0, 9))
        0:       pick_fw = '0;
        1:       pick_fw = 13'd1;
        2:       pick_fw = 13'd4096;
        3:       pick_fw = 13'($urandom_range(4097, 8191));
        default: pick_fw = 13'($urandom_range(2, 12));
      endcase
      set_all(8'($urandom), 8'($urandom), 8'($urandom), pick_thr, pick_fw);
      run_stream(100);
    end

    drain();
    if (fail_count == 0 && results_due == 0) begin
      $display("tb_color_match_centroid_tracker_unit: PASS");
    end else begin
      $display("tb_color_match_centroid_tracker_unit: FAIL");
    end
    $finish;
  end

endmodule

### filelist.f
sv/ccmt_pkg.sv
sv/ccmt_front.sv
sv/ccmt_queue.sv
sv/ccmt_div.sv
sv/ccmt_back.sv
sv/color_match_centroid_tracker_unit.sv
tb/sv/ccmt_tb_pkg.sv
tb/sv/ccmt_checker.sv
tb/sv/tb_color_match_centroid_tracker_unit.sv
